// ===== rtl/core/cdq_pkg.sv =====
// cdq_pkg: shared constants, types and index helpers for the circular deque.
// Depends on nothing; the other files in rtl/core but cdq_ram refer to it by scoped names.

package cdq_pkg;

    // Ring size and derived widths
    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Command codes; anything else acts as a query
    localparam logic [2:0] CMD_QUERY      = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_REAR   = 3'd4;

    // Value reported when there is no word
    localparam logic signed [WORD_W-1:0] NONE_WORD = '1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_LOAD
    } cdq_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic exec;      // update pointers, write or start the pop read
        logic fetch;     // take the popped word, read front and rear
        logic load;      // fill the output register
    } cdq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } cdq_stat_t;

    // Advance an index around the ring
    function automatic idx_t wrap_inc(input idx_t i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // Step an index back around the ring
    function automatic idx_t wrap_dec(input idx_t i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

endpackage

// ===== rtl/core/cdq_ram.sv =====
// cdq_ram: generic RAM, one write port and two registered read ports.
// Depends on nothing; sized by its WIDTH and DEPTH parameters.

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read two
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/core/cdq_ctrl.sv =====
// cdq_ctrl: sequencer for the circular deque, one command word at a time.
// Depends on cdq_pkg for the state enum and the command/status structs.

module cdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output cdq_pkg::cdq_cmd_t  ctl,
    input  cdq_pkg::cdq_stat_t stat
);

    cdq_pkg::cdq_state_t state_reg;
    cdq_pkg::cdq_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through exec, fetch and load
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cdq_pkg::ST_EXEC;
                end
            end
            cdq_pkg::ST_EXEC:
            begin
                state_next = cdq_pkg::ST_FETCH;
            end
            cdq_pkg::ST_FETCH:
            begin
                state_next = cdq_pkg::ST_LOAD;
            end
            cdq_pkg::ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = cdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive the datapath commands
    always_comb
    begin
        ctl      = '0;
        in_stall = 1'b1;
        case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                ctl.capture = in_valid;
            end
            cdq_pkg::ST_EXEC:
            begin
                ctl.exec = 1'b1;
            end
            cdq_pkg::ST_FETCH:
            begin
                ctl.fetch = 1'b1;
            end
            cdq_pkg::ST_LOAD:
            begin
                ctl.load = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/cdq_datapath.sv =====
// cdq_datapath: ring pointers, fill count, ring RAM and the output register.
// Depends on cdq_pkg and cdq_ram; steered by cdq_ctrl through cdq_cmd_t.

module cdq_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cdq_pkg::cdq_cmd_t            ctl,
    output cdq_pkg::cdq_stat_t           stat,
    input  logic [2:0]                   cmd,
    input  logic signed [cdq_pkg::WORD_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic signed [cdq_pkg::WORD_W-1:0] popped_value,
    output logic signed [cdq_pkg::WORD_W-1:0] front_value,
    output logic signed [cdq_pkg::WORD_W-1:0] rear_value,
    output logic                         is_empty,
    output logic                         is_full
);

    // Captured command word
    logic [2:0]                cmd_reg;
    logic [cdq_pkg::WORD_W-1:0] value_reg;

    // Ring state
    cdq_pkg::idx_t head_reg, head_next;
    cdq_pkg::idx_t tail_reg, tail_next;
    cdq_pkg::cnt_t count_reg, count_next;

    // Per-word results in flight
    logic                       ok_reg, ok_next;
    logic                       pop_hit_reg, pop_hit_next;
    logic [cdq_pkg::WORD_W-1:0] popped_reg;

    // Output register
    logic                       out_valid_reg;
    logic                       ok_out_reg;
    logic [cdq_pkg::WORD_W-1:0] popped_out_reg;
    logic [cdq_pkg::WORD_W-1:0] front_out_reg;
    logic [cdq_pkg::WORD_W-1:0] rear_out_reg;
    logic                       empty_out_reg;
    logic                       full_out_reg;

    // RAM ports
    logic                       wr_en;
    cdq_pkg::idx_t              wr_addr;
    cdq_pkg::idx_t              pop_addr;
    cdq_pkg::idx_t              rd_addr_a;
    cdq_pkg::idx_t              rd_addr_b;
    logic [cdq_pkg::WORD_W-1:0] rd_data_a;
    logic [cdq_pkg::WORD_W-1:0] rd_data_b;

    logic ring_full;
    logic ring_empty;

    assign ring_full  = (count_reg == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
    assign ring_empty = (count_reg == '0);

    // Decode the command against the fill state
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        ok_next      = 1'b1;
        pop_hit_next = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = tail_reg;
        pop_addr     = head_reg;
        case (cmd_reg)
            cdq_pkg::CMD_PUSH_FRONT:
            begin
                if (ring_full)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    head_next  = cdq_pkg::wrap_dec(head_reg);
                    wr_en      = 1'b1;
                    wr_addr    = cdq_pkg::wrap_dec(head_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            cdq_pkg::CMD_PUSH_REAR:
            begin
                if (ring_full)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    tail_next  = cdq_pkg::wrap_inc(tail_reg);
                    wr_en      = 1'b1;
                    wr_addr    = tail_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            cdq_pkg::CMD_POP_FRONT:
            begin
                if (ring_empty)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    pop_addr     = head_reg;
                    head_next    = cdq_pkg::wrap_inc(head_reg);
                    count_next   = count_reg - 1'b1;
                    pop_hit_next = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_REAR:
            begin
                if (ring_empty)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    pop_addr     = cdq_pkg::wrap_dec(tail_reg);
                    tail_next    = cdq_pkg::wrap_dec(tail_reg);
                    count_next   = count_reg - 1'b1;
                    pop_hit_next = 1'b1;
                end
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase
    end

    // Pop read during exec, front and rear reads during fetch
    assign rd_addr_a = ctl.exec ? pop_addr : head_reg;
    assign rd_addr_b = cdq_pkg::wrap_dec(tail_reg);

    cdq_ram #(
        .WIDTH (cdq_pkg::WORD_W),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_ring (
        .clk       (clk),
        .wr_en     (wr_en && ctl.exec),
        .wr_addr   (wr_addr),
        .wr_data   (value_reg),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // Latch the incoming word
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
        end
    end

    // Advance the ring pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            ok_reg      <= 1'b0;
            pop_hit_reg <= 1'b0;
        end
        else if (ctl.exec)
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            ok_reg      <= ok_next;
            pop_hit_reg <= pop_hit_next;
        end
    end

    // Take the popped word as it leaves the RAM
    always_ff @(posedge clk)
    begin
        if (ctl.fetch)
        begin
            popped_reg <= pop_hit_reg ? rd_data_a : cdq_pkg::NONE_WORD;
        end
    end

    // Hold the output word until the receiver takes it
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ok_out_reg     <= ok_reg;
            popped_out_reg <= popped_reg;
            front_out_reg  <= ring_empty ? cdq_pkg::NONE_WORD : rd_data_a;
            rear_out_reg   <= ring_empty ? cdq_pkg::NONE_WORD : rd_data_b;
            empty_out_reg  <= ring_empty;
            full_out_reg   <= ring_full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_out_reg;
    assign popped_value = popped_out_reg;
    assign front_value  = front_out_reg;
    assign rear_value   = rear_out_reg;
    assign is_empty     = empty_out_reg;
    assign is_full      = full_out_reg;

    // Head plus fill count, wrapped, must land on the tail
    logic [cdq_pkg::CNT_W:0] span_sum;
    logic [cdq_pkg::CNT_W:0] span_wrap;

    assign span_sum  = (cdq_pkg::CNT_W+1)'(head_reg) + (cdq_pkg::CNT_W+1)'(count_reg);
    assign span_wrap = (span_sum >= (cdq_pkg::CNT_W+1)'(cdq_pkg::DEPTH))
                     ? span_sum - (cdq_pkg::CNT_W+1)'(cdq_pkg::DEPTH) : span_sum;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH))
        else $error("fill count above ring depth");

    a_ring_span: assert property (@(posedge clk) disable iff (!rst_n)
        span_wrap[cdq_pkg::IDX_W-1:0] == tail_reg)
        else $error("head, tail and fill count disagree");

    a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && empty_out_reg |->
            front_out_reg == cdq_pkg::NONE_WORD && rear_out_reg == cdq_pkg::NONE_WORD)
        else $error("empty deque reports a front or rear word");

    a_fail_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_out_reg |-> popped_out_reg == cdq_pkg::NONE_WORD)
        else $error("failed command reports a popped word");

    a_state_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.exec |=> $stable(count_reg) && $stable(head_reg) && $stable(tail_reg))
        else $error("ring pointers moved outside exec");

endmodule

// ===== rtl/core/circular_deque.sv =====
// circular_deque: top level of the double-ended queue of 32-bit words.
// Depends on cdq_pkg, cdq_ctrl, cdq_datapath (and cdq_ram through it).
//
// Usage:
//   Input channel (in_valid / in_stall, cmd, value) carries one command word:
//   query, push front, push rear, pop front or pop rear; unknown codes query.
//   Output channel (out_valid / out_stall) returns exactly one result word per
//   command: ok, popped_value, front_value, rear_value, is_empty, is_full.
//   A push into a full ring or a pop from an empty one returns ok = 0 and
//   leaves the ring unchanged; missing words read as -1.
//   Each accepted command passes the exec, fetch and load steps in turn before
//   out_valid rises, and load waits while the output register is busy. A new
//   command is taken only after the last one is loaded, as the sequencer walks
//   it through the two-read-port ring RAM (pop read, then front and rear reads).
//   The output register decouples the sides: the next command is taken while
//   a result waits. With out_stall high the result holds, and a finished
//   command waits in the load step until the register frees.
//   Reset clears pointers, fill count and all handshake state; the ring RAM
//   is not cleared and no clearing pass is needed, since only held words are
//   ever read.

module circular_deque (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        cmd,
    input  logic signed [cdq_pkg::WORD_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              ok,
    output logic signed [cdq_pkg::WORD_W-1:0] popped_value,
    output logic signed [cdq_pkg::WORD_W-1:0] front_value,
    output logic signed [cdq_pkg::WORD_W-1:0] rear_value,
    output logic                              is_empty,
    output logic                              is_full
);

    cdq_pkg::cdq_cmd_t  ctl;
    cdq_pkg::cdq_stat_t stat;

    // Sequence each command word
    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ctl      (ctl),
        .stat     (stat)
    );

    // Ring, pointers and output register
    cdq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .popped_value (popped_value),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for circular_deque, the ring-based double-ended queue.
// Depends on cdq_pkg and circular_deque; predicts result words with its own deque model
// or takes them from typed directed rows, and drives both channels with random gaps and stalls.
`timescale 1ns / 1ps

module tb_top;

    localparam int  RAND_ITEMS  = 1500;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 40;

    // Unused command codes, which the block treats as a query
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    typedef struct packed {
        logic                         ok;
        logic [cdq_pkg::WORD_W-1:0]   popped;
        logic [cdq_pkg::WORD_W-1:0]   front;
        logic [cdq_pkg::WORD_W-1:0]   rear;
        logic                         empty;
        logic                         full;
    } deque_result_t;

    typedef struct {
        logic [2:0]                   op;
        logic [cdq_pkg::WORD_W-1:0]   word;
        bit                           typed;
        deque_result_t                want;
    } stim_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [2:0]                          cmd;
    logic signed [cdq_pkg::WORD_W-1:0]   value;
    logic                                out_valid;
    logic                                out_stall;
    logic                                ok;
    logic signed [cdq_pkg::WORD_W-1:0]   popped_value;
    logic signed [cdq_pkg::WORD_W-1:0]   front_value;
    logic signed [cdq_pkg::WORD_W-1:0]   rear_value;
    logic                                is_empty;
    logic                                is_full;

    // Deque model state
    logic [cdq_pkg::WORD_W-1:0]  slot_mem [cdq_pkg::DEPTH];
    cdq_pkg::idx_t               front_ptr;
    cdq_pkg::idx_t               back_ptr;
    cdq_pkg::cnt_t               held;

    deque_result_t      expected_q [$];
    stim_row_t          directed_rows [$];
    int                 errors;
    int                 cycle_count;
    bit                 quiet_spell;

    circular_deque u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .popped_value (popped_value),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic cdq_pkg::idx_t ptr_fwd(input cdq_pkg::idx_t i);
        return (i == cdq_pkg::idx_t'(cdq_pkg::DEPTH - 1))
             ? cdq_pkg::idx_t'(0) : cdq_pkg::idx_t'(i + 1);
    endfunction

    function automatic cdq_pkg::idx_t ptr_back(input cdq_pkg::idx_t i);
        return (i == cdq_pkg::idx_t'(0))
             ? cdq_pkg::idx_t'(cdq_pkg::DEPTH - 1) : cdq_pkg::idx_t'(i - 1);
    endfunction

    // Apply one command to the deque model and return the result word it yields
    function automatic deque_result_t deque_apply(input logic [2:0] op,
                                                  input logic [cdq_pkg::WORD_W-1:0] word);
        deque_result_t r;
        r.ok     = 1'b1;
        r.popped = cdq_pkg::NONE_WORD;
        r.front  = cdq_pkg::NONE_WORD;
        r.rear   = cdq_pkg::NONE_WORD;
        case (op)
            cdq_pkg::CMD_PUSH_FRONT:
            begin
                if (held == cdq_pkg::cnt_t'(cdq_pkg::DEPTH))
                    r.ok = 1'b0;
                else
                begin
                    front_ptr = ptr_back(front_ptr);
                    slot_mem[front_ptr] = word;
                    held = held + 1'b1;
                end
            end
            cdq_pkg::CMD_PUSH_REAR:
            begin
                if (held == cdq_pkg::cnt_t'(cdq_pkg::DEPTH))
                    r.ok = 1'b0;
                else
                begin
                    slot_mem[back_ptr] = word;
                    back_ptr = ptr_fwd(back_ptr);
                    held = held + 1'b1;
                end
            end
            cdq_pkg::CMD_POP_FRONT:
            begin
                if (held == '0)
                    r.ok = 1'b0;
                else
                begin
                    r.popped = slot_mem[front_ptr];
                    front_ptr = ptr_fwd(front_ptr);
                    held = held - 1'b1;
                end
            end
            cdq_pkg::CMD_POP_REAR:
            begin
                if (held == '0)
                    r.ok = 1'b0;
                else
                begin
                    back_ptr = ptr_back(back_ptr);
                    r.popped = slot_mem[back_ptr];
                    held = held - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        // Report both ends only while something is held
        if (held != '0)
        begin
            r.front = slot_mem[front_ptr];
            r.rear  = slot_mem[ptr_back(back_ptr)];
        end
        r.empty = (held == '0);
        r.full  = (held == cdq_pkg::cnt_t'(cdq_pkg::DEPTH));
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] op,
                                    input logic [cdq_pkg::WORD_W-1:0] word,
                                    input bit typed, input deque_result_t want);
        stim_row_t row;
        row.op    = op;
        row.word  = word;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Drive one command word, hold it until accepted, then record its expectation
    task automatic send_word(input logic [2:0] op, input logic [cdq_pkg::WORD_W-1:0] word,
                             input bit typed, input deque_result_t want);
        int            gap;
        deque_result_t predicted;
        gap = quiet_spell ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        value    <= word;
        do
            @(posedge clk);
        while (in_stall);
        predicted = deque_apply(op, word);
        expected_q.push_back(typed ? want : predicted);
    endtask

    function automatic void check_field(input string label,
                                        input logic [cdq_pkg::WORD_W-1:0] want,
                                        input logic [cdq_pkg::WORD_W-1:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, seen);
            errors++;
        end
    endfunction

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual ok=%b popped=%h",
                         $time, ok, popped_value);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("ok", cdq_pkg::WORD_W'(want.ok), cdq_pkg::WORD_W'(ok));
                check_field("popped_value", want.popped, popped_value);
                check_field("front_value", want.front, front_value);
                check_field("rear_value", want.rear, rear_value);
                check_field("is_empty", cdq_pkg::WORD_W'(want.empty),
                            cdq_pkg::WORD_W'(is_empty));
                check_field("is_full", cdq_pkg::WORD_W'(want.full),
                            cdq_pkg::WORD_W'(is_full));
            end
        end
    end

    // Stall the output side for a random number of cycles per result word
    initial
    begin
        int stall_n;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall_n = quiet_spell ? 0 : $urandom_range(0, 14);
            if (stall_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL circular_deque");
            $finish;
        end
    end

    initial
    begin
        int                          pick;
        bit                          lean_push;
        logic [2:0]                  op;
        logic [cdq_pkg::WORD_W-1:0]  word;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = cdq_pkg::CMD_QUERY;
        value       = '0;
        errors      = 0;
        cycle_count = 0;
        quiet_spell = 1'b0;
        lean_push   = 1'b1;
        front_ptr   = '0;
        back_ptr    = '0;
        held        = '0;

        // Empty deque, pops from empty, both word extremes, unused codes
        add_row(cdq_pkg::CMD_QUERY, $urandom, 1'b1,
                '{1'b1, cdq_pkg::NONE_WORD, cdq_pkg::NONE_WORD,
                  cdq_pkg::NONE_WORD, 1'b1, 1'b0});
        add_row(cdq_pkg::CMD_POP_FRONT, $urandom, 1'b1,
                '{1'b0, cdq_pkg::NONE_WORD, cdq_pkg::NONE_WORD,
                  cdq_pkg::NONE_WORD, 1'b1, 1'b0});
        add_row(cdq_pkg::CMD_POP_REAR, $urandom, 1'b1,
                '{1'b0, cdq_pkg::NONE_WORD, cdq_pkg::NONE_WORD,
                  cdq_pkg::NONE_WORD, 1'b1, 1'b0});
        add_row(cdq_pkg::CMD_PUSH_REAR, 32'h7FFF_FFFF, 1'b1,
                '{1'b1, cdq_pkg::NONE_WORD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0});
        add_row(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1'b1,
                '{1'b1, cdq_pkg::NONE_WORD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0});
        add_row(CMD_SPARE_A, $urandom, 1'b1,
                '{1'b1, cdq_pkg::NONE_WORD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0});
        add_row(CMD_SPARE_B, $urandom, 1'b1,
                '{1'b1, cdq_pkg::NONE_WORD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0});
        add_row(CMD_SPARE_C, $urandom, 1'b1,
                '{1'b1, cdq_pkg::NONE_WORD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0});
        // Fill to the top from both ends, zero and all-ones among the words
        add_row(cdq_pkg::CMD_PUSH_REAR, 32'h0000_0000, 1'b0, '0);
        add_row(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0);
        for (int k = 0; k < cdq_pkg::DEPTH - 4; k++)
            add_row((k % 2 == 0) ? cdq_pkg::CMD_PUSH_REAR : cdq_pkg::CMD_PUSH_FRONT,
                    $urandom, 1'b0, '0);
        // Push into a full ring at either end, then drain one from the rear
        add_row(cdq_pkg::CMD_PUSH_REAR, $urandom, 1'b0, '0);
        add_row(cdq_pkg::CMD_PUSH_FRONT, $urandom, 1'b0, '0);
        add_row(cdq_pkg::CMD_POP_REAR, $urandom, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].word,
                      directed_rows[i].typed, directed_rows[i].want);

        // Random commands, leaning toward pushes or pops in spells to sweep full and empty
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 96 == 0)
            begin
                lean_push   = 1'($urandom_range(0, 1));
                quiet_spell = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
                op = CMD_SPARE_A + 3'($urandom_range(0, 2));
            else if (pick < 8)
                op = cdq_pkg::CMD_QUERY;
            else if (pick < (lean_push ? 66 : 38))
                op = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_REAR;
            else
                op = $urandom_range(0, 1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_REAR;
            case ($urandom_range(0, 7))
                0:       word = 32'h7FFF_FFFF;
                1:       word = 32'h8000_0000;
                2:       word = '0;
                3:       word = '1;
                default: word = $urandom;
            endcase
            send_word(op, word, 1'b0, '0);
        end
        in_valid <= 1'b0;
        quiet_spell = 1'b0;

        // Drain outstanding results, then watch for strays
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("PASS circular_deque");
        else
            $display("FAIL circular_deque");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cdq_pkg.sv
rtl/core/cdq_ram.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_datapath.sv
rtl/core/circular_deque.sv
test/tb_top.sv
